// ----- hw/rtl/hbe_pkg.sv -----
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared types, constants and the coefficient table of the basis evaluator.
// ----------------------------------------------------------------------------
package hbe_pkg;

	localparam int DEG_W      = 2;
	localparam int IDX_W      = 3;
	localparam int COEF_W     = 13;
	localparam int GUARD_BITS = 8;
	localparam int ACC_INT_W  = 14;
	localparam int VAL_W      = 20;

	localparam int VAL_MIN = -(2 ** (VAL_W - 1));
	localparam int VAL_MAX = (2 ** (VAL_W - 1)) - 1;

	// value = floor((A + 768) / 1536), 1536 = 3 * 2^9
	localparam int ROUND_OFS = 3 * (2 ** GUARD_BITS);
	localparam int ROUND_SH  = GUARD_BITS + 1;

	localparam int SAT_LO = 3 * VAL_MIN;
	localparam int SAT_HI = 3 * VAL_MAX + 2;
	localparam int QU_W   = 22;
	localparam int QU_MAX = SAT_HI - SAT_LO;
	localparam int DIV_SH  = 24;
	localparam int DIV_MUL = ((2 ** DIV_SH) + 2) / 3;
	localparam int DMUL_W  = 23;

	typedef struct packed {
		logic [DEG_W-1:0] deg;
		logic [IDX_W-1:0] idx;
		logic             last;
	} hbe_tag_t;

	localparam logic signed [COEF_W-1:0] COEF_TAB [3][7][7] = '{
		'{
			'{13'sd6, -13'sd24, 13'sd18, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd36, -13'sd36, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, -13'sd12, 13'sd18, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0}
		},
		'{
			'{13'sd6, 13'sd0, -13'sd108, 13'sd192, -13'sd90, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd6, -13'sd27, 13'sd36, -13'sd15, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd180, -13'sd360, 13'sd180, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, -13'sd72, 13'sd168, -13'sd90, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd9, -13'sd24, 13'sd15, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0, 13'sd0}
		},
		'{
			'{13'sd6, 13'sd0, 13'sd0, -13'sd480, 13'sd1350, -13'sd1296, 13'sd420},
			'{13'sd0, 13'sd6, 13'sd0, -13'sd120, 13'sd300, -13'sd270, 13'sd84},
			'{13'sd0, 13'sd0, 13'sd3, -13'sd16, 13'sd30, -13'sd24, 13'sd7},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd840, -13'sd2520, 13'sd2520, -13'sd840},
			'{13'sd0, 13'sd0, 13'sd0, -13'sd360, 13'sd1170, -13'sd1224, 13'sd420},
			'{13'sd0, 13'sd0, 13'sd0, 13'sd60, -13'sd210, 13'sd234, -13'sd84},
			'{13'sd0, 13'sd0, 13'sd0, -13'sd4, 13'sd15, -13'sd18, 13'sd7}
		}
	};

	function automatic logic signed [COEF_W-1:0] coef_f(
		input logic [DEG_W-1:0] deg,
		input logic [IDX_W-1:0] idx,
		input logic [IDX_W-1:0] k
	);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (deg != '0 && idx != '1 && k != '1) begin
			c = COEF_TAB[deg - 2'd1][idx][k];
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/hermite_basis_eval.sv -----
// ----------------------------------------------------------------------------
// hermite_basis_eval
// Items of degree 1, 2 or 3 give 3, 5 or 7 basis functions, which the job
// issuer starts one per cycle while the output is not stalled; the pipeline
// (6 Horner stages, 4 rounding stages) takes a new job every cycle unless
// the output is stalled. Reset clears the valid bits and the issuer; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module hermite_basis_eval #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [hbe_pkg::DEG_W-1:0]            degree,
	input  logic [FRAC_BITS:0]                   position,
	output logic                                 basis_valid,
	input  logic                                 basis_stall,
	output logic [hbe_pkg::IDX_W-1:0]            basis_index,
	output logic signed [hbe_pkg::VAL_W-1:0]     basis_value,
	output logic                                 last
);
	import hbe_pkg::*;

	localparam int ACC_W  = FRAC_BITS + GUARD_BITS + ACC_INT_W;
	localparam int STEPS  = 6;

	logic                    adv;
	logic                    vld_h [0:STEPS];
	hbe_tag_t                tag_h [0:STEPS];
	logic [FRAC_BITS:0]      pos_h [0:STEPS];
	logic signed [ACC_W-1:0] acc_h [0:STEPS];

	assign adv = !basis_valid || !basis_stall;

	hbe_seq #(
		.FRAC_BITS(FRAC_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.degree    (degree),
		.position  (position),
		.vld_s1    (vld_h[0]),
		.tag_s1    (tag_h[0]),
		.pos_s1    (pos_h[0]),
		.acc_s1    (acc_h[0])
	);

	for (genvar j = 1; j <= STEPS; j++) begin : g_step
		hbe_horner #(
			.FRAC_BITS(FRAC_BITS),
			.K        (STEPS - j)
		) u_horner (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv),
			.vld_i (vld_h[j-1]),
			.tag_i (tag_h[j-1]),
			.pos_i (pos_h[j-1]),
			.acc_i (acc_h[j-1]),
			.vld_s1(vld_h[j]),
			.tag_s1(tag_h[j]),
			.pos_s1(pos_h[j]),
			.acc_s1(acc_h[j])
		);
	end

	hbe_round #(
		.FRAC_BITS(FRAC_BITS)
	) u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.vld_i   (vld_h[STEPS]),
		.tag_i   (tag_h[STEPS]),
		.acc_i   (acc_h[STEPS]),
		.vld_s4  (basis_valid),
		.idx_s4  (basis_index),
		.value_s4(basis_value),
		.last_s4 (last)
	);

endmodule

// ----- hw/rtl/hbe_seq.sv -----
// ----------------------------------------------------------------------------
// hbe_seq
// Takes input beats and issues one basis job per cycle into the pipeline while adv is high.
// ----------------------------------------------------------------------------
module hbe_seq #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   adv,
	input  logic                                                   item_valid,
	output logic                                                   item_stall,
	input  logic [hbe_pkg::DEG_W-1:0]                              degree,
	input  logic [FRAC_BITS:0]                                     position,
	output logic                                                   vld_s1,
	output hbe_pkg::hbe_tag_t                                      tag_s1,
	output logic [FRAC_BITS:0]                                     pos_s1,
	output logic signed [FRAC_BITS+hbe_pkg::GUARD_BITS+hbe_pkg::ACC_INT_W-1:0] acc_s1
);
	import hbe_pkg::*;

	localparam int G     = FRAC_BITS + GUARD_BITS;
	localparam int ACC_W = G + ACC_INT_W;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic             busy_q;
	logic [DEG_W-1:0] deg_q;
	logic [IDX_W-1:0] idx_q;
	logic [FRAC_BITS:0] pos_q;
	logic             issue;
	logic             last_iss;
	logic             accept;
	logic signed [ACC_W-1:0] acc0;

	assign last_iss   = (idx_q == {deg_q, 1'b0});
	assign issue      = busy_q && adv;
	assign item_stall = busy_q && !(adv && last_iss);
	assign accept     = item_valid && !item_stall;
	assign acc0       = ACC_W'(coef_f(deg_q, idx_q, IDX_W'(6))) <<< G;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (accept) begin
			busy_q <= (degree != '0);
			idx_q  <= '0;
		end else if (issue) begin
			if (last_iss) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deg_q <= degree;
			pos_q <= (position > ONE) ? ONE : position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1 <= '{deg: deg_q, idx: idx_q, last: last_iss};
			pos_s1 <= pos_q;
			acc_s1 <= acc0;
		end
	end

endmodule

// ----- hw/rtl/hbe_horner.sv -----
// ----------------------------------------------------------------------------
// hbe_horner
// One Horner step: A = floor(A * P / 2^FRAC_BITS) + c_k * 2^G, registered.
// ----------------------------------------------------------------------------
module hbe_horner #(
	parameter int FRAC_BITS = 16,
	parameter int K         = 0
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   adv,
	input  logic                                                   vld_i,
	input  hbe_pkg::hbe_tag_t                                      tag_i,
	input  logic [FRAC_BITS:0]                                     pos_i,
	input  logic signed [FRAC_BITS+hbe_pkg::GUARD_BITS+hbe_pkg::ACC_INT_W-1:0] acc_i,
	output logic                                                   vld_s1,
	output hbe_pkg::hbe_tag_t                                      tag_s1,
	output logic [FRAC_BITS:0]                                     pos_s1,
	output logic signed [FRAC_BITS+hbe_pkg::GUARD_BITS+hbe_pkg::ACC_INT_W-1:0] acc_s1
);
	import hbe_pkg::*;

	localparam int G      = FRAC_BITS + GUARD_BITS;
	localparam int ACC_W  = G + ACC_INT_W;
	localparam int PROD_W = ACC_W + FRAC_BITS + 2;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [ACC_W-1:0]  cterm;
	logic signed [ACC_W-1:0]  acc_nxt;

	assign prod    = PROD_W'(acc_i) * PROD_W'($signed({1'b0, pos_i}));
	assign prod_sh = prod >>> FRAC_BITS;
	assign cterm   = ACC_W'(coef_f(tag_i.deg, tag_i.idx, IDX_W'(K))) <<< G;
	assign acc_nxt = prod_sh[ACC_W-1:0] + cterm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_i) begin
			tag_s1 <= tag_i;
			pos_s1 <= pos_i;
			acc_s1 <= acc_nxt;
		end
	end

endmodule

// ----- hw/rtl/hbe_round.sv -----
// ----------------------------------------------------------------------------
// hbe_round
// Rounds the accumulator to Q4.16 by 1/1536, saturates, and holds the result.
// ----------------------------------------------------------------------------
module hbe_round #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   adv,
	input  logic                                                   vld_i,
	input  hbe_pkg::hbe_tag_t                                      tag_i,
	input  logic signed [FRAC_BITS+hbe_pkg::GUARD_BITS+hbe_pkg::ACC_INT_W-1:0] acc_i,
	output logic                                                   vld_s4,
	output logic [hbe_pkg::IDX_W-1:0]                              idx_s4,
	output logic signed [hbe_pkg::VAL_W-1:0]                       value_s4,
	output logic                                                   last_s4
);
	import hbe_pkg::*;

	localparam int ACC_W = FRAC_BITS + GUARD_BITS + ACC_INT_W;
	localparam int SUM_W = ACC_W - ROUND_SH;
	localparam int MAXW  = (SUM_W > QU_W + 1) ? SUM_W : QU_W + 1;
	localparam int PR_W  = QU_W + DMUL_W;
	localparam logic signed [MAXW-1:0] LO_W = MAXW'(SAT_LO);
	localparam logic signed [MAXW-1:0] HI_W = MAXW'(SAT_HI);

	logic [3:1]              vld_q;
	hbe_tag_t                tag_s1, tag_s2, tag_s3;
	logic signed [ACC_W-1:0] sum;
	logic signed [SUM_W-1:0] b_s1;
	logic signed [MAXW-1:0]  b_w;
	logic signed [MAXW-1:0]  diff;
	logic [QU_W-1:0]         u_nxt;
	logic [QU_W-1:0]         u_s2;
	logic [PR_W-1:0]         prod_s3;
	logic [VAL_W-1:0]        q;

	assign sum  = acc_i + ACC_W'(ROUND_OFS);
	assign b_w  = MAXW'(b_s1);
	assign diff = b_w - LO_W;
	assign q    = prod_s3[DIV_SH +: VAL_W];

	always_comb begin
		if (b_w < LO_W) begin
			u_nxt = '0;
		end else if (b_w > HI_W) begin
			u_nxt = QU_W'(QU_MAX);
		end else begin
			u_nxt = diff[QU_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_q  <= {vld_q[2:1], vld_i};
			vld_s4 <= vld_q[3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s1     <= sum[ACC_W-1:ROUND_SH];
			tag_s1   <= tag_i;
			u_s2     <= u_nxt;
			tag_s2   <= tag_s1;
			prod_s3  <= PR_W'(u_s2) * PR_W'(DIV_MUL);
			tag_s3   <= tag_s2;
			// rebias from offset binary
			value_s4 <= {~q[VAL_W-1], q[VAL_W-2:0]};
			idx_s4   <= tag_s3.idx;
			last_s4  <= tag_s3.last;
		end
	end

endmodule
